@@ rtl/gppid_pkg.sv @@
// Shared types, constants and the sine table of the gimbal pitch PID controller.
package gppid_pkg;

    // Sine table size: quarter wave, SINE_TABLE_ENTRIES + 1 points.
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);

    // Channel and field widths.
    localparam int GYRO_W      = 16;
    localparam int CMD_W       = 21;
    localparam int SERVO_W     = 8;
    localparam int Q_W         = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CMD_W - SERVO_W - 2 * Q_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed-point constants of the control law.
    localparam int RATE_K         = 5722;     // 0.01 * pi / 180 / 131 in Q32
    localparam int DEG_TO_RAD_Q16 = 1144;     // pi / 180 in Q16
    localparam int TICK_Q16       = 655;      // 0.01 in Q16
    localparam int DERIV_MUL      = 100;      // 1 / 0.01
    localparam int ACCEL_TICK_Q16 = 26214;    // 40 * 0.01 in Q16
    localparam int CMD_LIMIT      = 655360;   // 10.0 in Q16.16

    // Sine index divide by 90 * 65536, done as a reciprocal multiply.
    localparam int DIV_D      = 90 * 65536;
    localparam int DIV_D_HALF = 90 * 32768;
    localparam int RCP_MUL    = 728;          // floor(2^32 / DIV_D)
    localparam longint RCP_BIAS = longint'(DIV_D_HALF) * longint'(RCP_MUL);

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_HIGH_SETPT = 3'd3,
        CFG_ALT_THRESH = 3'd4
    } cfg_idx_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [15:0]        gain_prop;
        logic [15:0]        gain_integ;
        logic [15:0]        gain_deriv;
        logic signed [7:0]  high_setpoint_deg;
        logic [14:0]        altitude_threshold_m;
    } cfg_t;

    localparam logic [15:0]       RST_GAIN_PROP  = 16'd4096;
    localparam logic [15:0]       RST_GAIN_INTEG = 16'd410;
    localparam logic [15:0]       RST_GAIN_DERIV = 16'd205;
    localparam logic signed [7:0] RST_HIGH_SETPT = 8'sd10;
    localparam logic [14:0]       RST_ALT_THRESH = 15'd500;

    // Quarter-wave sine table, Q16, computed at elaboration by a Taylor series.
    typedef logic [16:0] sine_lut_t [0:SINE_TABLE_ENTRIES];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t          lut;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            lut[i] = 17'((64'(sum) + 64'd8192) >> 14);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ rtl/gimbal_pitch_pid_controller_unit.sv @@
// Top level of the gimbal pitch PID controller: sequencer and shared-multiplier datapath.
//
// Usage:
//   Each word on the s_ channel is one 10 ms control tick carrying a raw gyro
//   pitch rate. The block integrates it into a pitch angle, runs a clamped PID
//   step, simulates the resulting climb, and returns one word on the m_
//   channel: command, servo angle, pitch and altitude.
//   The cfg_ channel writes the gains, the high setpoint and the altitude
//   threshold; it is always ready. It must be written only between ticks; the block does not enforce this.
// Sequence:
//   A word is taken in the idle state and then runs through the 20 sequencer
//   steps in order, the last of which loads the result and raises m_tvalid.
//   The steps follow from the single 33 x 25 bit multiplier, which every
//   product of the tick shares in turn, with a product register ahead of
//   each writeback. s_tready is high only while the sequencer is idle.
// Reset:
//   aresetn (synchronous, active low) clears the integrators, the last error,
//   the output valid flag and the sequencer, and restores the register defaults.
// Stall:
//   The result sits in an output register, so the next word is accepted while
//   the receiver stalls; the following result waits in the last step until
//   that register is free.
module gimbal_pitch_pid_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input words.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gppid_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] gyro_pitch_raw
    // Result words.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [20:0] gimbal_command, [28:21] servo_position, [60:29] pitch_estimate,
    // [92:61] altitude_estimate, [95:93] zero
    output logic [gppid_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gppid_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gppid_pkg::*;

    localparam int A_W    = 33;
    localparam int B_W    = 25;
    localparam int PROD_W = A_W + B_W;
    localparam int WIDE_W = PROD_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } fsm_t;

    typedef enum logic [4:0] {
        STP_RATE, STP_SETP, STP_KD,  STP_ERRI, STP_KP,
        STP_KI,   STP_KDD,  STP_SUM, STP_CMD,  STP_ABS,
        STP_RCP,  STP_QUO,  STP_BCK, STP_IDX,  STP_SIN,
        STP_VEL,  STP_VWB,  STP_POS, STP_PWB,  STP_OUT
    } step_t;

    // Round half up after a 16 bit shift.
    function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [WIDE_W-1:0] t;
        t = WIDE_W'(p) + WIDE_W'(32768);
        return t >>> 16;
    endfunction

    // Saturate to the signed 32 bit range.
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[WIDE_W-1:Q_W-1] == {(WIDE_W-Q_W+1){v[WIDE_W-1]}}) begin
            r = v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    cfg_t cfg;

    fsm_t  fsm_reg;
    step_t step_reg;

    // Tick state.
    logic signed [Q_W-1:0]    pitch_reg;
    logic signed [Q_W-1:0]    ei_reg;
    logic signed [Q_W-1:0]    last_err_reg;
    logic signed [Q_W-1:0]    vel_reg;
    logic signed [Q_W-1:0]    pos_reg;
    logic                     m_tvalid_reg;

    // Working registers of one tick.
    logic signed [GYRO_W-1:0] gyro_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    err_reg;
    logic [22:0]              kd100_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [CMD_W-1:0]  cmd_reg;
    logic [A_W-1:0]           num_reg;
    logic [IDX_W-1:0]         q0_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [17:0]       sin_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic                     above_thresh;
    logic signed [Q_W-1:0]    wb_base;
    logic signed [Q_W-1:0]    wb_sat;
    logic signed [Q_W-1:0]    err_next;
    logic signed [PROD_W-1:0] acc_rnd;
    logic signed [CMD_W-1:0]  cmd_next;
    logic                     cmd_neg;
    logic [CMD_W-2:0]         cmd_abs;
    logic [PROD_W-1:0]        q_sum;
    logic [A_W:0]             rem;
    logic [IDX_W:0]           idx_sum;
    logic [IDX_W-1:0]         idx_next;
    logic [16:0]              lut_val;
    logic [4:0]               servo_base;
    logic [SERVO_W-1:0]       servo;
    logic                     accept;
    logic                     out_free;

    gppid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_tready = (fsm_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Setpoint is zero until the simulated altitude passes the threshold.
    assign above_thresh = pos_reg > $signed({1'b0, cfg.altitude_threshold_m, 16'b0});

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            STP_RATE: begin
                mul_a = A_W'(gyro_reg);
                mul_b = B_W'(RATE_K);
            end
            STP_SETP: begin
                mul_a = above_thresh ? A_W'($signed(cfg.high_setpoint_deg)) : '0;
                mul_b = B_W'(DEG_TO_RAD_Q16);
            end
            STP_KD: begin
                mul_a = {17'b0, cfg.gain_deriv};
                mul_b = B_W'(DERIV_MUL);
            end
            STP_ERRI: begin
                mul_a = A_W'(err_reg);
                mul_b = B_W'(TICK_Q16);
            end
            STP_KP: begin
                mul_a = A_W'(err_reg);
                mul_b = {9'b0, cfg.gain_prop};
            end
            STP_KI: begin
                mul_a = A_W'(ei_reg);
                mul_b = {9'b0, cfg.gain_integ};
            end
            STP_KDD: begin
                mul_a = A_W'(err_reg) - A_W'(last_err_reg);
                mul_b = {2'b0, kd100_reg};
            end
            STP_ABS: begin
                mul_a = {13'b0, cmd_abs};
                mul_b = B_W'(SINE_TABLE_ENTRIES);
            end
            STP_RCP: begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = B_W'(RCP_MUL);
            end
            STP_BCK: begin
                mul_a = A_W'(q0_reg);
                mul_b = B_W'(DIV_D);
            end
            STP_VEL: begin
                mul_a = A_W'(sin_reg);
                mul_b = B_W'(ACCEL_TICK_Q16);
            end
            STP_POS: begin
                mul_a = A_W'(vel_reg);
                mul_b = B_W'(TICK_Q16);
            end
            default: ;
        endcase
    end

    // Shared rounding accumulate into one of the integrators.
    always_comb begin
        unique case (step_reg)
            STP_SETP: wb_base = pitch_reg;
            STP_KP:   wb_base = ei_reg;
            STP_VWB:  wb_base = vel_reg;
            STP_PWB:  wb_base = pos_reg;
            default:  wb_base = '0;
        endcase
        wb_sat   = sat32(WIDE_W'(wb_base) + rnd16(prod_reg));
        err_next = sat32(WIDE_W'(prod_reg) - WIDE_W'(pitch_reg));
    end

    // PID sum rounding and output clamp.
    always_comb begin
        acc_rnd = (acc_reg + PROD_W'(2048)) >>> 12;
        if (acc_rnd > PROD_W'(CMD_LIMIT)) begin
            cmd_next = CMD_W'(CMD_LIMIT);
        end else if (acc_rnd < -PROD_W'(CMD_LIMIT)) begin
            cmd_next = -CMD_W'(CMD_LIMIT);
        end else begin
            cmd_next = acc_rnd[CMD_W-1:0];
        end
    end

    // Sine index: reciprocal quotient, one correction, clamp to the table end.
    always_comb begin
        cmd_neg = cmd_reg[CMD_W-1];
        cmd_abs = cmd_neg ? (CMD_W-1)'(-cmd_reg) : (CMD_W-1)'(cmd_reg);
        q_sum   = prod_reg + PROD_W'(RCP_BIAS);
        rem     = (A_W+1)'(num_reg) - prod_reg[A_W:0];
        idx_sum = (IDX_W+1)'(q0_reg) + (IDX_W+1)'(rem >= (A_W+1)'(DIV_D));
        if (idx_sum > (IDX_W+1)'(SINE_TABLE_ENTRIES)) begin
            idx_next = IDX_W'(SINE_TABLE_ENTRIES);
        end else begin
            idx_next = idx_sum[IDX_W-1:0];
        end
        lut_val = SINE_LUT[idx_reg];
    end

    // Servo angle from the command truncated toward zero: (whole + 10) * 9.
    always_comb begin
        servo_base = cmd_neg ? 5'd10 - {1'b0, cmd_abs[19:16]}
                             : 5'd10 + {1'b0, cmd_abs[19:16]};
        servo      = {servo_base, 3'b000} + SERVO_W'(servo_base);
    end

    // Sequencer and integrators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= ST_IDLE;
            step_reg     <= STP_RATE;
            pitch_reg    <= '0;
            ei_reg       <= '0;
            last_err_reg <= '0;
            vel_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            unique case (fsm_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fsm_reg  <= ST_RUN;
                        step_reg <= STP_RATE;
                    end
                end
                ST_RUN: begin
                    if (step_reg != STP_OUT) begin
                        step_reg <= step_t'(step_reg + 5'd1);
                    end
                    unique case (step_reg)
                        STP_SETP: pitch_reg    <= wb_sat;
                        STP_KP:   ei_reg       <= wb_sat;
                        STP_CMD:  last_err_reg <= err_reg;
                        STP_VWB:  vel_reg      <= wb_sat;
                        STP_PWB:  pos_reg      <= wb_sat;
                        STP_OUT: begin
                            if (out_free) begin
                                fsm_reg <= ST_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: fsm_reg <= ST_IDLE;
            endcase
        end
    end

    // Output valid: set when a result is loaded, cleared when the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((fsm_reg == ST_RUN) && (step_reg == STP_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Product register and working values of the tick.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (accept) begin
            gyro_reg <= $signed(s_tdata[GYRO_W-1:0]);
        end
        if (fsm_reg == ST_RUN) begin
            unique case (step_reg)
                STP_KD:   err_reg   <= err_next;
                STP_ERRI: kd100_reg <= prod_reg[22:0];
                STP_KI:   acc_reg   <= prod_reg;
                STP_KDD:  acc_reg   <= acc_reg + prod_reg;
                STP_SUM:  acc_reg   <= acc_reg + prod_reg;
                STP_CMD:  cmd_reg   <= cmd_next;
                STP_RCP:  num_reg   <= prod_reg[A_W-1:0] + A_W'(DIV_D_HALF);
                STP_QUO:  q0_reg    <= q_sum[32 +: IDX_W];
                STP_IDX:  idx_reg   <= idx_next;
                STP_SIN:  sin_reg   <= cmd_neg ? -$signed({1'b0, lut_val})
                                               : $signed({1'b0, lut_val});
                STP_OUT: begin
                    if (out_free) begin
                        out_data_reg <= {{OUT_PAD_W{1'b0}}, pos_reg, pitch_reg, servo, cmd_reg};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/gppid_cfg.sv @@
// Configuration register file of the gimbal pitch PID controller.
module gppid_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gppid_pkg::CFG_DATA_W-1:0]    cfg_data,
    output gppid_pkg::cfg_t                     cfg
);
    import gppid_pkg::*;

    cfg_t cfg_reg;

    // The user must issue writes only while the block is idle; the block does not enforce it. The port never stalls.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; indexes beyond the map are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop            <= RST_GAIN_PROP;
            cfg_reg.gain_integ           <= RST_GAIN_INTEG;
            cfg_reg.gain_deriv           <= RST_GAIN_DERIV;
            cfg_reg.high_setpoint_deg    <= RST_HIGH_SETPT;
            cfg_reg.altitude_threshold_m <= RST_ALT_THRESH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_PROP:  cfg_reg.gain_prop            <= cfg_data;
                CFG_GAIN_INTEG: cfg_reg.gain_integ           <= cfg_data;
                CFG_GAIN_DERIV: cfg_reg.gain_deriv           <= cfg_data;
                CFG_HIGH_SETPT: cfg_reg.high_setpoint_deg    <= $signed(cfg_data[7:0]);
                CFG_ALT_THRESH: cfg_reg.altitude_threshold_m <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/gppid_checker.sv @@
// Port-level checks of the gimbal pitch PID controller, bound to the top level.
module gppid_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gppid_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import gppid_pkg::*;

    logic signed [CMD_W-1:0] cmd_field;
    assign cmd_field = $signed(m_tdata[CMD_W-1:0]);

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // The sequencer is busy right after it takes a word.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    // A result never appears in the cycle right after an accept.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result word too early after accept");

    // The command stays within its clamp and the servo angle within 0 to 180.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cmd_field <= CMD_W'(CMD_LIMIT)) && (cmd_field >= -CMD_W'(CMD_LIMIT))
                     && (m_tdata[28:21] <= 8'd180))
        else $error("result fields out of range");

endmodule

bind gimbal_pitch_pid_controller_unit gppid_checker u_gppid_checker (.*);
